// ===== sv/bmvm_pkg.sv =====
// Shared types, constants and helpers for the banded matrix-vector multiply core.
// No dependencies; used by banded_matrix_vector_multiply_core.
package bmvm_pkg;

  localparam int BAND_WIDTH        = 10;
  localparam int FIRST_SHIFTED_ROW = 6;
  localparam int BAND_LEAD         = 4;

  localparam int ROW_W  = 6;
  localparam int SIZE_W = 7;
  localparam int DATA_W = 32;
  localparam int PROD_W = 64;
  localparam int RES_W  = 48;
  localparam int ACC_W  = 53;
  localparam int TERM_W = 4;

  localparam logic signed [ACC_W-1:0] RES_MAX = 53'sh00_7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] RES_MIN = 53'sh1F_8000_0000_0000;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  // configuration register indexes
  localparam logic CFG_SIZE      = 1'b0;
  localparam logic CFG_TRANSPOSE = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE_ENTRY  = 2'd0,
    OP_WRITE_VECTOR = 2'd1,
    OP_COMPUTE      = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_RUN   = 2'd2,
    ST_DONE  = 2'd3
  } state_e;

  // first column of a row's band
  function automatic logic [ROW_W-1:0] band_start(input logic [ROW_W-1:0] r);
    logic [ROW_W-1:0] d;
    begin
      d = r - ROW_W'(BAND_LEAD);
      return (r < ROW_W'(FIRST_SHIFTED_ROW)) ? '0 : {d[ROW_W-1:1], 1'b0};
    end
  endfunction

endpackage

// ===== sv/bmvm_ram.sv =====
// Single-port-write, single-port-read RAM with registered read data.
// No dependencies; instanced for the band stores and the vector store.
module bmvm_ram #(
  parameter int DEPTH = 640,
  parameter int WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/banded_matrix_vector_multiply_core.sv =====
// Banded matrix-vector multiply core: band stores, vector store and one shared MAC.
// Depends on bmvm_pkg and bmvm_ram.
//
//   Channel   Direction  Signals                          Transaction
//   s_axis    in         tvalid tready tdata[95:0] tuser  one operation
//   m_axis    out        tvalid tready tdata[55:0] tuser  one row result
//   cfg       in         cfg_we_i cfg_index_i cfg_data_i  one register write
//
// After reset the band stores are swept to zero, one entry of each per cycle, over all
// MAX_SIZE*10 entries (640 by default); s_axis_tready stays low meanwhile.
// For a row compute, from acceptance to result, the MAC issues one band read per
// cycle, then RAM read, multiply and accumulate drain.
// A held result on m_axis stalls only the final load.
module banded_matrix_vector_multiply_core #(
  parameter int MAX_SIZE = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // row[5:0] column[11:6] value[43:12] use_transpose[44] addend[92:45], zero pad
  input  logic [95:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // result_row[5:0] result_value[53:6], zero pad
  output logic [55:0] m_axis_tdata,
  // saturated[0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int DEPTH = MAX_SIZE * bmvm_pkg::BAND_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int VW    = $clog2(MAX_SIZE);
  localparam int ROW_W = bmvm_pkg::ROW_W;
  localparam int ACC_W = bmvm_pkg::ACC_W;
  localparam int RES_W = bmvm_pkg::RES_W;

  bmvm_pkg::state_e state_q, state_d;

  logic [bmvm_pkg::SIZE_W-1:0] size_q;
  logic                        transp_q;
  logic [bmvm_pkg::SIZE_W-1:0] size_eff;

  logic [AW-1:0]                clr_cnt_q;
  logic [bmvm_pkg::TERM_W-1:0]  issue_cnt_q;
  logic [bmvm_pkg::TERM_W-1:0]  terms_q;
  logic [AW-1:0]                base_q;
  logic [ROW_W-1:0]             start_q;
  logic [ROW_W-1:0]             row_q;
  logic                         sel_t_q;
  logic                         rd_vld_q;
  logic                         prod_vld_q;
  logic signed [bmvm_pkg::PROD_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0]      acc_q;

  logic                         m_valid_q;
  logic [ROW_W-1:0]             m_row_q;
  logic [RES_W-1:0]             m_val_q;
  logic                         m_sat_q;

  // unpacked input fields
  bmvm_pkg::op_e          in_op;
  logic [ROW_W-1:0]       in_row;
  logic [ROW_W-1:0]       in_col;
  logic [31:0]            in_val;
  logic                   in_ut;
  logic [RES_W-1:0]       in_add;

  assign in_op  = bmvm_pkg::op_e'(s_axis_tuser);
  assign in_row = s_axis_tdata[5:0];
  assign in_col = s_axis_tdata[11:6];
  assign in_val = s_axis_tdata[43:12];
  assign in_ut  = s_axis_tdata[44];
  assign in_add = s_axis_tdata[92:45];

  assign size_eff = (size_q > bmvm_pkg::SIZE_W'(MAX_SIZE)) ?
                    bmvm_pkg::SIZE_W'(MAX_SIZE) : size_q;

  // control from the sequencer
  logic accept, clearing, issue, pipe_busy, load_out;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign pipe_busy = rd_vld_q || prod_vld_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      bmvm_pkg::ST_CLEAR: begin
        if (clr_cnt_q == AW'(DEPTH - 1)) state_d = bmvm_pkg::ST_IDLE;
      end
      bmvm_pkg::ST_IDLE: begin
        if (accept && in_op == bmvm_pkg::OP_COMPUTE) state_d = bmvm_pkg::ST_RUN;
      end
      bmvm_pkg::ST_RUN: begin
        if (issue_cnt_q == terms_q && !pipe_busy) state_d = bmvm_pkg::ST_DONE;
      end
      bmvm_pkg::ST_DONE: begin
        if (!m_valid_q || m_axis_tready) state_d = bmvm_pkg::ST_IDLE;
      end
      default: state_d = bmvm_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    s_axis_tready = 1'b0;
    clearing      = 1'b0;
    issue         = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      bmvm_pkg::ST_CLEAR: clearing      = 1'b1;
      bmvm_pkg::ST_IDLE:  s_axis_tready = 1'b1;
      bmvm_pkg::ST_RUN:   issue         = (issue_cnt_q < terms_q);
      bmvm_pkg::ST_DONE:  load_out      = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  // entry write addressing
  logic [ROW_W-1:0] row_start, col_start, col_off, row_off;
  logic             entry_ok, t_ok, vec_ok;
  logic [AW-1:0]    ent_addr, t_addr;

  assign row_start = bmvm_pkg::band_start(in_row);
  assign col_start = bmvm_pkg::band_start(in_col);
  assign col_off   = in_col - row_start;
  assign row_off   = in_row - col_start;
  assign entry_ok  = ({1'b0, in_row} < size_eff) && ({1'b0, in_col} < size_eff) &&
                     (in_col >= row_start) && (col_off < ROW_W'(bmvm_pkg::BAND_WIDTH));
  assign t_ok      = transp_q && (in_row >= col_start) &&
                     (row_off < ROW_W'(bmvm_pkg::BAND_WIDTH));
  assign vec_ok    = ({1'b0, in_col} < bmvm_pkg::SIZE_W'(MAX_SIZE));
  assign ent_addr  = AW'(int'(in_row) * bmvm_pkg::BAND_WIDTH + int'(col_off));
  assign t_addr    = AW'(int'(in_col) * bmvm_pkg::BAND_WIDTH + int'(row_off));

  logic          band_we, tband_we, vec_we;
  logic [AW-1:0] band_waddr, tband_waddr, rd_addr;
  logic [31:0]   wdata;
  logic [VW-1:0] vec_raddr;
  logic [31:0]   band_rdata, tband_rdata, vec_rdata;

  assign band_we     = clearing || (accept && in_op == bmvm_pkg::OP_WRITE_ENTRY && entry_ok);
  assign tband_we    = clearing ||
                       (accept && in_op == bmvm_pkg::OP_WRITE_ENTRY && entry_ok && t_ok);
  assign vec_we      = accept && in_op == bmvm_pkg::OP_WRITE_VECTOR && vec_ok;
  assign band_waddr  = clearing ? clr_cnt_q : ent_addr;
  assign tband_waddr = clearing ? clr_cnt_q : t_addr;
  assign wdata       = clearing ? '0 : in_val;
  assign rd_addr     = base_q + AW'(issue_cnt_q);
  assign vec_raddr   = VW'({1'b0, start_q} + {3'b000, issue_cnt_q});

  bmvm_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_band (
    .clk_i   (clk_i),
    .we_i    (band_we),
    .waddr_i (band_waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (band_rdata)
  );

  bmvm_ram #(.DEPTH(DEPTH), .WIDTH(32)) u_tband (
    .clk_i   (clk_i),
    .we_i    (tband_we),
    .waddr_i (tband_waddr),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rd_addr),
    .rdata_o (tband_rdata)
  );

  bmvm_ram #(.DEPTH(MAX_SIZE), .WIDTH(32)) u_vec (
    .clk_i   (clk_i),
    .we_i    (vec_we),
    .waddr_i (VW'(in_col)),
    .wdata_i (in_val),
    .re_i    (issue),
    .raddr_i (vec_raddr),
    .rdata_o (vec_rdata)
  );

  // shared MAC: multiply registered RAM data, then accumulate floored Q32.16 term
  logic signed [31:0] a_data, x_data;
  assign a_data = sel_t_q ? tband_rdata : band_rdata;
  assign x_data = vec_rdata;
  assign prod_d = a_data * x_data;

  // terms of the accepted row
  logic [bmvm_pkg::SIZE_W-1:0] span;
  logic [bmvm_pkg::TERM_W-1:0] terms_d;
  assign span    = size_eff - {1'b0, row_start};
  assign terms_d = ({1'b0, in_row} >= size_eff) ? '0 :
                   (span > bmvm_pkg::SIZE_W'(bmvm_pkg::BAND_WIDTH)) ?
                   bmvm_pkg::TERM_W'(bmvm_pkg::BAND_WIDTH) : span[bmvm_pkg::TERM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bmvm_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      issue_cnt_q <= '0;
      terms_q     <= '0;
      rd_vld_q    <= 1'b0;
      prod_vld_q  <= 1'b0;
      m_valid_q   <= 1'b0;
      size_q      <= bmvm_pkg::SIZE_RESET;
      transp_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_vld_q   <= issue;
      prod_vld_q <= rd_vld_q;
      if (clearing) clr_cnt_q <= clr_cnt_q + AW'(1);
      if (accept && in_op == bmvm_pkg::OP_COMPUTE) begin
        issue_cnt_q <= '0;
        terms_q     <= terms_d;
      end else if (issue) begin
        issue_cnt_q <= issue_cnt_q + bmvm_pkg::TERM_W'(1);
      end
      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          bmvm_pkg::CFG_SIZE:      size_q   <= cfg_data_i;
          bmvm_pkg::CFG_TRANSPOSE: transp_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    if (accept && in_op == bmvm_pkg::OP_COMPUTE) begin
      base_q  <= AW'(int'(in_row) * bmvm_pkg::BAND_WIDTH);
      start_q <= row_start;
      row_q   <= in_row;
      sel_t_q <= in_ut && transp_q;
      acc_q   <= {{(ACC_W - RES_W){in_add[RES_W-1]}}, in_add};
    end else if (prod_vld_q) begin
      acc_q <= acc_q + {{(ACC_W - RES_W){prod_q[63]}}, prod_q[63:16]};
    end
    if (rd_vld_q) prod_q <= prod_d;
    if (load_out) begin
      m_row_q <= row_q;
      if (acc_q > bmvm_pkg::RES_MAX) begin
        m_val_q <= bmvm_pkg::RES_MAX[RES_W-1:0];
        m_sat_q <= 1'b1;
      end else if (acc_q < bmvm_pkg::RES_MIN) begin
        m_val_q <= bmvm_pkg::RES_MIN[RES_W-1:0];
        m_sat_q <= 1'b1;
      end else begin
        m_val_q <= acc_q[RES_W-1:0];
        m_sat_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {2'b00, m_val_q, m_row_q};
  assign m_axis_tuser  = m_sat_q;

  a_accept_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> state_q == bmvm_pkg::ST_IDLE)
    else $error("transaction accepted outside idle");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bmvm_pkg::ST_RUN |-> issue_cnt_q <= terms_q)
    else $error("MAC issued past the row's band");

  a_pipe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prod_vld_q |-> $past(rd_vld_q))
    else $error("product valid without read data");

  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == bmvm_pkg::ST_DONE)
    else $error("result raised outside row completion");

  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bmvm_pkg::ST_DONE |-> !rd_vld_q && !prod_vld_q)
    else $error("row finished with MAC still busy");

endmodule
